// ----- rtl/pada_pkg.sv -----
// Shared types and constants of the pairwise absolute difference accumulator.
`default_nettype none
package pada_pkg;

    localparam int unsigned VAL_W     = 16;
    localparam int unsigned BLK_W     = 8;
    localparam int unsigned CNT_W     = 21;
    localparam int unsigned SUM_W     = 36;
    localparam int unsigned TOT_W     = 63;
    localparam int unsigned CLR_W     = VAL_W + 1;
    localparam int unsigned MAX_ITEMS = 1048576;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] sum;
    } t_tally;

    typedef struct packed {
        logic accept;     // input transfer, reset the step counter
        logic cnt_inc;    // stored value count goes up by one
        logic clear_wr;   // write zeros at the clearing address
        logic sweep_rd;   // read the sweep entry at the step counter
        logic look_rd;    // read the entries that belong to the value
        logic add_en;
        logic mul_en;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic sweep_last;
        logic full;
        logic insert;
    } t_status;

endpackage
`default_nettype wire

// ----- rtl/pada_datapath.sv -----
// Datapath: the four tally memories, the sweep update and the difference sum.
`default_nettype none
module pada_datapath
    import pada_pkg::*;
#(
    parameter int unsigned ITEM_LIMIT = MAX_ITEMS
)
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    output t_status               o_status,
    input  wire logic             i_operation,
    input  wire logic [VAL_W-1:0] i_value,
    output logic [SUM_W-1:0]      o_difference_sum,
    output logic [TOT_W-1:0]      o_running_total,
    output logic                  o_full_res
);

    localparam int unsigned FINE_D = 2 ** VAL_W;
    localparam int unsigned BLK_D  = 2 ** BLK_W;

    t_tally r_fine_below [FINE_D];
    t_tally r_fine_above [FINE_D];
    t_tally r_blk_below  [BLK_D];
    t_tally r_blk_above  [BLK_D];

    logic             r_op;
    logic [VAL_W-1:0] r_v;
    logic             r_full;
    logic [CLR_W-1:0] r_step;
    logic [CNT_W-1:0] r_count;
    logic             r_wr_pend;
    logic [BLK_W-1:0] r_wr_idx;

    t_tally r_fb_rd, r_fa_rd, r_bb_rd, r_ba_rd;

    logic [CNT_W:0]     r_lc, r_gc;
    logic [SUM_W:0]     r_ls, r_gs;
    logic [CNT_W+VAL_W:0] r_lprod, r_gprod;
    logic [SUM_W:0]     r_ls2, r_gs2;

    logic [SUM_W-1:0] r_diff;
    logic [TOT_W-1:0] r_total;
    logic [TOT_W-1:0] r_total_o;
    logic             r_full_res;

    logic [BLK_W-1:0] blk, off;
    logic [VAL_W-1:0] fine_ra, fine_wa;
    logic [BLK_W-1:0] blk_ra, blk_wa;
    logic             fb_we, fa_we, bb_we, ba_we;
    t_tally           fb_wd, fa_wd, bb_wd, ba_wd;
    t_tally           add_v;
    logic [CNT_W+VAL_W+1:0] diff_full;

    assign blk   = r_v[VAL_W-1 -: BLK_W];
    assign off   = r_v[BLK_W-1:0];
    assign add_v = '{cnt: CNT_W'(1), sum: SUM_W'(r_v)};

    always_comb begin
        if (i_cmd.look_rd) begin
            fine_ra = r_v;
            blk_ra  = blk;
        end else begin
            fine_ra = {blk, r_step[BLK_W-1:0]};
            blk_ra  = r_step[BLK_W-1:0];
        end
        if (i_cmd.clear_wr) begin
            fine_wa = r_step[VAL_W-1:0];
            blk_wa  = r_step[BLK_W-1:0];
            fb_we = 1'b1; fa_we = 1'b1; bb_we = 1'b1; ba_we = 1'b1;
            fb_wd = '0;   fa_wd = '0;   bb_wd = '0;   ba_wd = '0;
        end else begin
            fine_wa = {blk, r_wr_idx};
            blk_wa  = r_wr_idx;
            // Entries strictly above the value count it as smaller, below as larger.
            fb_we = r_wr_pend && (r_wr_idx > off);
            fa_we = r_wr_pend && (r_wr_idx < off);
            bb_we = r_wr_pend && (r_wr_idx > blk);
            ba_we = r_wr_pend && (r_wr_idx < blk);
            fb_wd = '{cnt: r_fb_rd.cnt + add_v.cnt, sum: r_fb_rd.sum + add_v.sum};
            fa_wd = '{cnt: r_fa_rd.cnt + add_v.cnt, sum: r_fa_rd.sum + add_v.sum};
            bb_wd = '{cnt: r_bb_rd.cnt + add_v.cnt, sum: r_bb_rd.sum + add_v.sum};
            ba_wd = '{cnt: r_ba_rd.cnt + add_v.cnt, sum: r_ba_rd.sum + add_v.sum};
        end
    end

    always_ff @(posedge i_clk) begin
        if (fb_we) r_fine_below[fine_wa] <= fb_wd;
        if (fa_we) r_fine_above[fine_wa] <= fa_wd;
        if (bb_we) r_blk_below[blk_wa]   <= bb_wd;
        if (ba_we) r_blk_above[blk_wa]   <= ba_wd;
        r_fb_rd <= r_fine_below[fine_ra];
        r_fa_rd <= r_fine_above[fine_ra];
        r_bb_rd <= r_blk_below[blk_ra];
        r_ba_rd <= r_blk_above[blk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= '0;
            r_count   <= '0;
            r_total   <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            r_wr_pend <= i_cmd.sweep_rd;
            if (i_cmd.accept) begin
                r_step <= '0;
            end else if (i_cmd.clear_wr || i_cmd.sweep_rd) begin
                r_step <= r_step + CLR_W'(1);
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.out_load && r_op == OP_INSERT && !r_full) begin
                r_total <= r_total + TOT_W'(diff_full[SUM_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_idx <= r_step[BLK_W-1:0];
        if (i_cmd.accept) begin
            r_op   <= i_operation;
            r_v    <= i_value;
            r_full <= (i_operation == OP_INSERT) && (r_count >= CNT_W'(ITEM_LIMIT));
        end
        if (i_cmd.add_en) begin
            r_lc <= {1'b0, r_fb_rd.cnt} + {1'b0, r_bb_rd.cnt};
            r_gc <= {1'b0, r_fa_rd.cnt} + {1'b0, r_ba_rd.cnt};
            r_ls <= {1'b0, r_fb_rd.sum} + {1'b0, r_bb_rd.sum};
            r_gs <= {1'b0, r_fa_rd.sum} + {1'b0, r_ba_rd.sum};
        end
        if (i_cmd.mul_en) begin
            r_lprod <= r_lc * r_v;
            r_gprod <= r_gc * r_v;
            r_ls2   <= r_ls;
            r_gs2   <= r_gs;
        end
        if (i_cmd.out_load) begin
            r_diff     <= diff_full[SUM_W-1:0];
            r_total_o  <= (r_op == OP_INSERT && !r_full)
                          ? r_total + TOT_W'(diff_full[SUM_W-1:0]) : r_total;
            r_full_res <= r_full;
        end
    end

    // Only the low bits matter: the true sum is never negative.
    assign diff_full = ((CNT_W+VAL_W+2)'(r_lprod) - (CNT_W+VAL_W+2)'(r_ls2))
                     + ((CNT_W+VAL_W+2)'(r_gs2) - (CNT_W+VAL_W+2)'(r_gprod));

    assign o_status.clear_last = (r_step == CLR_W'(FINE_D - 1));
    assign o_status.sweep_last = (r_step[BLK_W-1:0] == BLK_W'(BLK_D - 1));
    assign o_status.full       = (r_count >= CNT_W'(ITEM_LIMIT));
    assign o_status.insert     = (i_operation == OP_INSERT);

    assign o_difference_sum = r_diff;
    assign o_running_total  = r_total_o;
    assign o_full_res       = r_full_res;

endmodule
`default_nettype wire

// ----- rtl/pada_controller.sv -----
// Controller: sequences clearing, the table sweep, the lookup and the result.
`default_nettype none
module pada_controller
    import pada_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    output logic         o_valid,
    input  wire logic    i_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_SWEEP = 8'b0000_0100,
        S_DRAIN = 8'b0000_1000,
        S_LOOK  = 8'b0001_0000,
        S_ADD   = 8'b0010_0000,
        S_MUL   = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   take, store, out_free;

    assign take     = (r_state == S_IDLE) && i_valid;
    assign store    = i_status.insert && !i_status.full;
    assign out_free = !r_valid || i_ready;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid && !i_ready;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_status.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (take) begin
                    o_cmd.accept  = 1'b1;
                    o_cmd.cnt_inc = store;
                    n_state       = store ? S_SWEEP : S_LOOK;
                end
            end
            S_SWEEP: begin
                o_cmd.sweep_rd = 1'b1;
                if (i_status.sweep_last) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_LOOK;
            S_LOOK: begin
                o_cmd.look_rd = 1'b1;
                n_state       = S_ADD;
            end
            S_ADD: begin
                o_cmd.add_en = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_valid        = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

endmodule
`default_nettype wire

// ----- rtl/pairwise_abs_difference_accumulator_unit.sv -----
// Top level of the pairwise absolute difference accumulator.
//
//  channel | direction | signals
//  --------+-----------+------------------------------------------------------
//  input   | in        | i_valid, o_ready, i_operation, i_value
//  result  | out       | o_valid, i_ready, o_difference_sum, o_running_total,
//          |           | o_full_res
//
// After reset the tables are cleared, one fine entry per cycle, with o_ready
// low meanwhile. An insert sweeps 256 entries of each table through a
// read-modify-write that reads one entry while it writes back the one before;
// a query or a refused insert skips the sweep. A finished result sits in the
// output register; a new transfer is taken meanwhile, and the next result is
// held in state S_FIN until i_ready frees the output register.
`default_nettype none
module pairwise_abs_difference_accumulator_unit
    import pada_pkg::*;
#(
    parameter int unsigned ITEM_LIMIT = MAX_ITEMS
)
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic             i_operation,
    input  wire logic [VAL_W-1:0] i_value,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [SUM_W-1:0]      o_difference_sum,
    output logic [TOT_W-1:0]      o_running_total,
    output logic                  o_full_res
);

    t_cmd    cmd;
    t_status status;

    pada_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    pada_datapath #(
        .ITEM_LIMIT (ITEM_LIMIT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_operation      (i_operation),
        .i_value          (i_value),
        .o_difference_sum (o_difference_sum),
        .o_running_total  (o_running_total),
        .o_full_res       (o_full_res)
    );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the pairwise absolute difference accumulator.
`default_nettype none
module tb;
    import pada_pkg::*;

    typedef struct {
        logic [SUM_W-1:0] diff;
        logic [TOT_W-1:0] total;
        logic             full;
    } t_answer;

    typedef struct {
        logic        op;
        int unsigned val;
        bit          typed;
        longint      diff;
        longint      total;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             i_operation = OP_INSERT;
    logic [VAL_W-1:0] i_value = '0;
    logic             i_ready = 1'b0;
    logic             o_ready;
    logic             o_valid;
    logic [SUM_W-1:0] o_difference_sum;
    logic [TOT_W-1:0] o_running_total;
    logic             o_full_res;

    pairwise_abs_difference_accumulator_unit dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state: the stored values kept as a plain list.
    int unsigned      stored_values[$];
    logic [TOT_W-1:0] total_model = '0;
    t_answer          pending_answers[$];
    int               error_count = 0;
    longint           cycle_count = 0;

    task automatic report_mismatch(input string what);
        $display("error at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    function automatic logic [SUM_W-1:0] abs_diff_sum(input int unsigned v);
        longint acc;
        acc = 0;
        foreach (stored_values[k])
            acc += (v > stored_values[k]) ? v - stored_values[k] : stored_values[k] - v;
        return acc[SUM_W-1:0];
    endfunction

    function automatic t_answer predict_step(input logic op, input int unsigned v);
        t_answer a;
        a.full = 1'b0;
        if (op == OP_INSERT) begin
            if (stored_values.size() >= MAX_ITEMS) begin
                a.full = 1'b1;
            end else begin
                stored_values.insert(stored_values.size(), v);
                total_model = total_model + abs_diff_sum(v);
            end
        end
        a.diff = abs_diff_sum(v);
        a.total = total_model;
        return a;
    endfunction

    // Transfer on the input channel; the expectation is queued at acceptance.
    task automatic send_item(input logic op, input int unsigned v, input bit typed,
                             input longint d, input longint t);
        t_answer a;
        int      gap;
        i_valid     <= 1'b1;
        i_operation <= op;
        i_value     <= v[VAL_W-1:0];
        do @(posedge i_clk); while (!o_ready);
        a = predict_step(op, v);
        if (typed) begin
            a.diff  = d[SUM_W-1:0];
            a.total = t[TOT_W-1:0];
        end
        pending_answers.insert(pending_answers.size(), a);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400) : $urandom_range(0, 3);
        if ($urandom_range(0, 4) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("pairwise_abs_difference_accumulator_unit: mismatch");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                t_answer a;
                a = pending_answers.pop_front();
                if (o_difference_sum !== a.diff)
                    report_mismatch($sformatf("difference_sum %0d, expected %0d",
                                              o_difference_sum, a.diff));
                if (o_running_total !== a.total)
                    report_mismatch($sformatf("running_total %0d, expected %0d",
                                              o_running_total, a.total));
                if (o_full_res !== a.full)
                    report_mismatch($sformatf("full_res %0b, expected %0b",
                                              o_full_res, a.full));
            end
        end
    end

    // Receiver stalls: mostly short, now and then long, with stall-free stretches.
    always @(posedge i_clk) begin
        static int hold = 0;
        static bit calm = 1'b0;
        if (hold > 0) begin
            hold--;
        end else begin
            calm = ($urandom_range(0, 3) == 0);
            hold = calm ? $urandom_range(50, 2000)
                        : (($urandom_range(0, 9) == 0) ? $urandom_range(30, 600)
                                                       : $urandom_range(0, 4));
            i_ready <= calm ? 1'b1 : ~i_ready;
        end
    end

    t_row directed[] = '{
        '{OP_QUERY,  0,     1, 0,      0},
        '{OP_QUERY,  65535, 1, 0,      0},
        '{OP_INSERT, 0,     1, 0,      0},
        '{OP_INSERT, 65535, 1, 65535,  65535},
        '{OP_QUERY,  0,     1, 65535,  65535},
        '{OP_QUERY,  65535, 1, 65535,  65535},
        '{OP_INSERT, 65535, 1, 65535,  131070},
        '{OP_INSERT, 255,   0, 0, 0},
        '{OP_INSERT, 256,   0, 0, 0},
        '{OP_INSERT, 256,   0, 0, 0},
        '{OP_QUERY,  256,   0, 0, 0},
        '{OP_QUERY,  257,   0, 0, 0},
        '{OP_INSERT, 65280, 0, 0, 0},
        '{OP_INSERT, 65279, 0, 0, 0},
        '{OP_INSERT, 32768, 0, 0, 0},
        '{OP_QUERY,  32767, 0, 0, 0},
        '{OP_INSERT, 21845, 0, 0, 0},
        '{OP_INSERT, 43690, 0, 0, 0},
        '{OP_QUERY,  0,     0, 0, 0},
        '{OP_INSERT, 0,     0, 0, 0}
    };

    initial begin
        int unsigned v;
        logic        op;
        int          guard;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[r])
            send_item(directed[r].op, directed[r].val, directed[r].typed,
                      directed[r].diff, directed[r].total);
        for (int n = 0; n < 550; n++) begin
            op = ($urandom_range(0, 9) < 7) ? OP_INSERT : OP_QUERY;
            case ($urandom_range(0, 9))
                0:       v = stored_values[$urandom_range(0, stored_values.size() - 1)];
                1:       v = $urandom_range(0, 1) ? 0 : 65535;
                2:       v = $urandom_range(0, 255) * 256 + ($urandom_range(0, 1) ? 255 : 0);
                default: v = $urandom_range(0, 65535);
            endcase
            send_item(op, v, 1'b0, 0, 0);
            if (n == 200) begin
                i_valid <= 1'b0;
                while (pending_answers.size() != 0) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        guard = 0;
        while (guard < 400) begin
            @(posedge i_clk);
            guard++;
        end
        if (error_count == 0)
            $display("pairwise_abs_difference_accumulator_unit: match");
        else
            $display("pairwise_abs_difference_accumulator_unit: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
